/* hdl/drp_pkg.sv */
// ----------------------------------------------------------------------------
// drp_pkg
// shared types, constants and rainbow ramp tables for the depth overlay
// ----------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

	localparam int DEPTH_BITS = 16;
	localparam int NUM_W      = DEPTH_BITS + 8;
	localparam int DIV_STAGES = 8;
	localparam int RAMP_LEN   = 52;
	localparam int RAMP_IDX_W = $clog2(RAMP_LEN);

	// segment edges of the rainbow map
	localparam logic [7:0] SEG1 = 8'd51;
	localparam logic [7:0] SEG2 = 8'd102;
	localparam logic [7:0] SEG3 = 8'd153;
	localparam logic [7:0] SEG4 = 8'd204;
	localparam logic [7:0] FULL = 8'd255;
	localparam logic [7:0] HALF = 8'd127;

	typedef enum logic [1:0] {
		REG_MIN_DEPTH = 2'd0,
		REG_MAX_DEPTH = 2'd1,
		REG_OVERLAY   = 2'd2
	} drp_reg_t;

	typedef struct packed {
		logic [DEPTH_BITS-1:0] depth_sample;
		logic [7:0]            cam_blue;
		logic [7:0]            cam_green;
		logic [7:0]            cam_red;
	} drp_in_t;

	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       depth_present;
	} drp_out_t;

	// per-pixel info that rides along with the division
	typedef struct packed {
		logic       nz;
		logic       sat_hi;
		logic       sat_lo;
		logic [7:0] cam_b;
		logic [7:0] cam_g;
		logic [7:0] cam_r;
	} drp_side_t;

	typedef logic [RAMP_LEN-1:0][7:0] ramp_t;

	// rounded k*t/102 ramp, evaluated at elaboration
	function automatic ramp_t build_ramp(input int unsigned k);
		ramp_t r;
		for (int t = 0; t < RAMP_LEN; t++) begin
			r[t] = 8'((k * t + 51) / 102);
		end
		return r;
	endfunction

	localparam ramp_t RAMP_HI = build_ramp(256);
	localparam ramp_t RAMP_LO = build_ramp(254);

endpackage

`default_nettype wire

/* hdl/drp_prep.sv */
// ----------------------------------------------------------------------------
// drp_prep
// limit compare, offset and range, then numerator scaled by 255
// ----------------------------------------------------------------------------
`default_nettype none

module drp_prep
	import drp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [DEPTH_BITS-1:0] lo_lim,
	input  wire logic [DEPTH_BITS-1:0] hi_lim,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire drp_in_t               in_pix,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [NUM_W-1:0]           num,
	output logic [DEPTH_BITS-1:0]      rng,
	output drp_side_t                  side
);

	logic                  v_s1, v_s2;
	logic                  en_s1, en_s2;
	logic [DEPTH_BITS-1:0] n_s1, rng_s1, rng_s2;
	logic [NUM_W-1:0]      num_s2;
	drp_side_t             side_s1, side_s2;
	logic [DEPTH_BITS-1:0] rng_c;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign rng_c    = hi_lim - lo_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			n_s1           <= in_pix.depth_sample - lo_lim;
			rng_s1         <= rng_c;
			side_s1.nz     <= (in_pix.depth_sample != '0);
			side_s1.sat_hi <= (in_pix.depth_sample > hi_lim);
			side_s1.sat_lo <= (in_pix.depth_sample < lo_lim) || (rng_c == '0);
			side_s1.cam_b  <= in_pix.cam_blue;
			side_s1.cam_g  <= in_pix.cam_green;
			side_s1.cam_r  <= in_pix.cam_red;
		end
		if (en_s2) begin
			// n * 255 as n * 256 - n
			num_s2  <= {n_s1, 8'd0} - NUM_W'(n_s1);
			rng_s2  <= rng_s1;
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign num       = num_s2;
	assign rng       = rng_s2;
	assign side      = side_s2;

endmodule

`default_nettype wire

/* hdl/drp_div.sv */
// ----------------------------------------------------------------------------
// drp_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module drp_div
	import drp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [NUM_W-1:0]      num,
	input  wire logic [DEPTH_BITS-1:0] rng,
	input  wire drp_side_t             in_side,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 quo,
	output drp_side_t                  out_side
);

	logic                  v_s   [DIV_STAGES];
	logic                  en_s  [DIV_STAGES];
	logic [NUM_W-1:0]      rem_s [DIV_STAGES];
	logic [DEPTH_BITS-1:0] rng_s [DIV_STAGES];
	logic [7:0]            quo_s [DIV_STAGES];
	drp_side_t             side_s[DIV_STAGES];

	// ready ripples back from the last stage
	always_comb begin
		en_s[DIV_STAGES-1] = !v_s[DIV_STAGES-1] || out_ready;
		for (int k = DIV_STAGES - 2; k >= 0; k--) begin
			en_s[k] = !v_s[k] || en_s[k+1];
		end
	end

	assign in_ready = en_s[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam int B = DIV_STAGES - 1 - k;
		logic                  v_i;
		logic [NUM_W-1:0]      rem_i;
		logic [DEPTH_BITS-1:0] rng_i;
		logic [7:0]            quo_i;
		drp_side_t             side_i;
		logic [NUM_W-1:0]      sub;
		logic                  take;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = num;
			assign rng_i  = rng;
			assign quo_i  = '0;
			assign side_i = in_side;
		end else begin : g_next
			assign v_i    = v_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign rng_i  = rng_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign sub  = NUM_W'(rng_i) << B;
		assign take = (rem_i >= sub);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en_s[k]) begin
				v_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				rem_s[k]  <= take ? (rem_i - sub) : rem_i;
				rng_s[k]  <= rng_i;
				quo_s[k]  <= quo_i | (8'(take) << B);
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES-1];
	assign quo       = quo_s[DIV_STAGES-1];
	assign out_side  = side_s[DIV_STAGES-1];

endmodule

`default_nettype wire

/* hdl/drp_cmap.sv */
// ----------------------------------------------------------------------------
// drp_cmap
// gray select, five-segment rainbow map, overlay mux and output register
// ----------------------------------------------------------------------------
`default_nettype none

module drp_cmap
	import drp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       overlay_enable,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] quo,
	input  wire drp_side_t  side,
	output logic            out_valid,
	input  wire logic       out_ready,
	output drp_out_t        res
);

	logic       v_s11;
	logic       en_s11;
	drp_out_t   res_s11;
	logic [7:0] gray;
	logic [7:0] t;
	logic [7:0] t5;
	logic [7:0] cb, cg, cr;
	drp_out_t   res_c;

	assign en_s11   = !v_s11 || out_ready;
	assign in_ready = en_s11;

	always_comb begin
		if (side.sat_hi) begin
			gray = FULL;
		end else if (side.sat_lo) begin
			gray = '0;
		end else begin
			gray = quo;
		end
	end

	always_comb begin
		priority if (gray <= SEG1) begin
			t = gray;
		end else if (gray <= SEG2) begin
			t = gray - SEG1;
		end else if (gray <= SEG3) begin
			t = gray - SEG2;
		end else if (gray <= SEG4) begin
			t = gray - SEG3;
		end else begin
			t = gray - SEG4;
		end
		t5 = (t << 2) + t;

		priority if (gray <= SEG1) begin
			cb = FULL;
			cg = t5;
			cr = '0;
		end else if (gray <= SEG2) begin
			cb = FULL - t5;
			cg = FULL;
			cr = '0;
		end else if (gray <= SEG3) begin
			cb = '0;
			cg = FULL;
			cr = t5;
		end else if (gray <= SEG4) begin
			cb = '0;
			cg = FULL - RAMP_HI[t[RAMP_IDX_W-1:0]];
			cr = FULL;
		end else begin
			cb = '0;
			cg = HALF - RAMP_LO[t[RAMP_IDX_W-1:0]];
			cr = FULL;
		end
	end

	always_comb begin
		if (side.nz) begin
			res_c.out_blue      = cb;
			res_c.out_green     = cg;
			res_c.out_red       = cr;
			res_c.depth_present = 1'b1;
		end else if (overlay_enable) begin
			res_c.out_blue      = side.cam_b;
			res_c.out_green     = side.cam_g;
			res_c.out_red       = side.cam_r;
			res_c.depth_present = 1'b0;
		end else begin
			res_c.out_blue      = '0;
			res_c.out_green     = '0;
			res_c.out_red       = '0;
			res_c.depth_present = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en_s11) begin
			v_s11 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s11) begin
			res_s11 <= res_c;
		end
	end

	assign out_valid = v_s11;
	assign res       = res_s11;

endmodule

`default_nettype wire

/* hdl/depth_rainbow_overlay.sv */
// ----------------------------------------------------------------------------
// depth_rainbow_overlay
// depth sample to rainbow color, overlaid on the camera pixel
// ----------------------------------------------------------------------------
// pipeline: 11 register stages
// throughput: one pixel per clock while not stalled; every stage takes a new request each cycle unless stalled
// stalls: each stage holds while the stage after it is full and blocked
// reset: pipeline emptied, lower limit 0, upper limit all ones, overlay on
// ----------------------------------------------------------------------------
`default_nettype none

module depth_rainbow_overlay
	import drp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// pixel request channel
	input  wire logic                  pix_valid,
	output logic                       pix_ready,
	input  wire drp_in_t               pix,
	// result channel
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output drp_out_t                   res,
	// register write port
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_idx,
	input  wire logic [DEPTH_BITS-1:0] cfg_wdata
);

	// limit and mode registers
	logic [DEPTH_BITS-1:0] lo_lim_q;
	logic [DEPTH_BITS-1:0] hi_lim_q;
	logic                  overlay_q;

	// prep -> divider
	logic                  prep_valid, prep_ready;
	logic [NUM_W-1:0]      prep_num;
	logic [DEPTH_BITS-1:0] prep_rng;
	drp_side_t             prep_side;

	// divider -> color map
	logic                  div_valid, div_ready;
	logic [7:0]            div_quo;
	drp_side_t             div_side;

	// register writes; unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_lim_q  <= '0;
			hi_lim_q  <= '1;
			overlay_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIN_DEPTH: lo_lim_q  <= cfg_wdata;
				REG_MAX_DEPTH: hi_lim_q  <= cfg_wdata;
				REG_OVERLAY:   overlay_q <= cfg_wdata[0];
				default:       ;
			endcase
		end
	end

	// stages 1-2: saturation flags, offset, range and 255x numerator
	drp_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.lo_lim    (lo_lim_q),
		.hi_lim    (hi_lim_q),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.in_pix    (pix),
		.out_valid (prep_valid),
		.out_ready (prep_ready),
		.num       (prep_num),
		.rng       (prep_rng),
		.side      (prep_side)
	);

	// stages 3-10: gray = num / range, one bit per stage, msb first
	// quotient fits 8 bits when offset does not exceed range; other samples are overridden by the saturation flags
	drp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prep_valid),
		.in_ready  (prep_ready),
		.num       (prep_num),
		.rng       (prep_rng),
		.in_side   (prep_side),
		.out_valid (div_valid),
		.out_ready (div_ready),
		.quo       (div_quo),
		.out_side  (div_side)
	);

	// stage 11: saturation override, rainbow lookup, overlay select
	drp_cmap u_cmap (
		.clk            (clk),
		.arst_n         (arst_n),
		.overlay_enable (overlay_q),
		.in_valid       (div_valid),
		.in_ready       (div_ready),
		.quo            (div_quo),
		.side           (div_side),
		.out_valid      (res_valid),
		.out_ready      (res_ready),
		.res            (res)
	);

endmodule

`default_nettype wire
